@@ rtl/lcm_pkg.sv @@
// Shared types, widths and codes for the LED crossfade mixer.
package lcm_pkg;

   // Q16 fixed point: 65536 stands for 1.0
   localparam int Q_W         = 17;
   localparam logic [Q_W-1:0] Q_ONE = 17'h10000;
   localparam int FRAC_W      = 16;
   localparam int DELTA_W     = 16;
   localparam int BRIGHT_W    = 17;
   localparam int DUR_W       = 20;
   localparam int PROG_W      = 21;
   localparam logic [PROG_W-1:0] PROG_MAX = 21'h1FFFFF;
   localparam int EFFECT_ID_BITS = 8;
   localparam int QUEUE_DEPTH = 3;

   // serial arithmetic sizing
   localparam int MUL_DIGITS  = (Q_W + 1) / 2;   // radix-4 digits of a multiplier
   localparam int DIV_STEPS   = FRAC_W;          // quotient bits below 1.0

   // request codes
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_SWITCH = 2'd1;
   localparam logic [1:0] REQ_ENABLE = 2'd2;

   // notify codes
   localparam logic [1:0] NOTE_NONE = 2'd0;
   localparam logic [1:0] NOTE_OFF  = 2'd1;
   localparam logic [1:0] NOTE_ON   = 2'd2;

   // register map
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_DURATION = 4'd1;

   typedef struct packed {
      logic [1:0]                req_type;
      logic [DELTA_W-1:0]        delta;
      logic [EFFECT_ID_BITS-1:0] effect_id;
      logic                      enable_value;
   } req_item_type;

   typedef struct packed {
      logic [EFFECT_ID_BITS-1:0] front_effect;
      logic                      front_valid;
      logic [Q_W-1:0]            front_weight;
      logic [EFFECT_ID_BITS-1:0] next_effect;
      logic                      next_valid;
      logic [Q_W-1:0]            next_weight;
      logic [1:0]                notify;
   } rsp_item_type;

endpackage

@@ rtl/lcm_ser_mul.sv @@
// Radix-4 digit-serial Q16 multiplier: returns floor(mcand*mplier/65536).
module lcm_ser_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lcm_pkg::Q_W-1:0]   mcand,
   input  logic [lcm_pkg::Q_W-1:0]   mplier,
   output logic                      busy,
   output logic [lcm_pkg::Q_W-1:0]   prod_hi
);

   localparam int MPL_W = 2 * lcm_pkg::MUL_DIGITS;
   localparam int ACC_W = lcm_pkg::Q_W + MPL_W;
   localparam int CNT_W = $clog2(lcm_pkg::MUL_DIGITS);
   localparam int PP_W  = lcm_pkg::Q_W + 2;

   logic                      busy_ff, busy_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [lcm_pkg::Q_W-1:0]   mcand_ff, mcand_in;
   logic [MPL_W-1:0]          mplier_ff, mplier_in;
   logic [1:0]                digit;
   logic [PP_W-1:0]           pp;

   // partial product for the top radix-4 digit
   always_comb begin
      digit = mplier_ff[MPL_W-1 -: 2];
      pp    = ({1'b0, mcand_ff, 1'b0} & {PP_W{digit[1]}})
            + ({2'b00, mcand_ff} & {PP_W{digit[0]}});
   end

   // one digit per cycle, most significant first
   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         count_in  = CNT_W'(lcm_pkg::MUL_DIGITS - 1);
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = MPL_W'(mplier);
      end else if (busy_ff) begin
         acc_in    = {acc_ff[ACC_W-3:0], 2'b00} + ACC_W'(pp);
         mplier_in = {mplier_ff[MPL_W-3:0], 2'b00};
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff  <= count_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign busy    = busy_ff;
   assign prod_hi = acc_ff[lcm_pkg::FRAC_W +: lcm_pkg::Q_W];

endmodule

@@ rtl/lcm_ser_div.sv @@
// Bit-serial restoring divider for the fade fraction x = min(1, num*65536/den).
module lcm_ser_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lcm_pkg::PROG_W-1:0] num,
   input  logic [lcm_pkg::DUR_W-1:0]  den,
   output logic                       busy,
   output logic [lcm_pkg::Q_W-1:0]    quot
);

   localparam int STEP_W = $clog2(lcm_pkg::DIV_STEPS);

   logic                       busy_ff, busy_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [lcm_pkg::DUR_W-1:0]  rem_ff, rem_in;
   logic [lcm_pkg::DUR_W-1:0]  den_ff, den_in;
   logic [lcm_pkg::Q_W-1:0]    quot_ff, quot_in;
   logic [lcm_pkg::DUR_W:0]    rem_sh;
   logic                       q_bit;

   // trial subtract of the shifted remainder
   always_comb begin
      rem_sh = {rem_ff, 1'b0};
      q_bit  = (rem_sh >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         den_in = den;
         // zero duration or progress at/over duration: full fade
         if ((den == '0) || (num >= {1'b0, den})) begin
            quot_in = lcm_pkg::Q_ONE;
         end else begin
            busy_in = 1'b1;
            step_in = STEP_W'(lcm_pkg::DIV_STEPS - 1);
            rem_in  = num[lcm_pkg::DUR_W-1:0];
            quot_in = '0;
         end
      end else if (busy_ff) begin
         if (q_bit) begin
            rem_in = rem_sh[lcm_pkg::DUR_W-1:0] - den_ff;
         end else begin
            rem_in = rem_sh[lcm_pkg::DUR_W-1:0];
         end
         quot_in = {quot_ff[lcm_pkg::Q_W-2:0], q_bit};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/led_effect_crossfade_mixer_core.sv @@
// Top level of the LED crossfade mixer: state update, sequencer and result register.
//
// Usage: requests arrive on the req_ channel (valid/stall); each accepted beat is a
// tick, a switch to an effect or a set-enable. Every request yields exactly one
// result beat on the rsp_ channel with the two front effect ids, their Q16 mix
// weights and a turn-on/turn-off notify code, all taken from the state after the
// request. Registers brightness (index 0) and fade_duration (index 1) are written
// on the csr_ channel, which is always ready; write them only while idle.
// Sequence: the state updates at acceptance, then level^2 and brightness*level^2
// run on a radix-4 serial multiplier while a bit-serial divider forms the fade
// fraction, then both weights run in parallel on two multipliers. The result is
// loaded at the end of this chain, and the next request can be taken in the same
// cycle as the result is shown, so only one request is in flight at a time.
// req_stall is high from acceptance until the result is loaded. A finished result
// waits in the output register while rsp_stall is high; computing the next item
// proceeds meanwhile and holds only at the load step.
// Reset (synchronous) clears the flag, level, progress and queue count, sets the
// registers to 1.0 and drops any pending result; the queue entries hold no reset.
module led_effect_crossfade_mixer_core #(
   parameter int QUEUE_DEPTH = lcm_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lcm_pkg::req_item_type                req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lcm_pkg::rsp_item_type                rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lcm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int ID_W  = lcm_pkg::EFFECT_ID_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_LEV2, S_BRIGHT, S_WEIGHT, S_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lcm_pkg::rsp_item_type        rsp_ff, rsp_in;

   logic [lcm_pkg::BRIGHT_W-1:0] bright_ff;
   logic [lcm_pkg::DUR_W-1:0]    dur_ff;

   logic                         enable_ff, enable_in;
   logic [lcm_pkg::Q_W-1:0]      level_ff, level_in;
   logic [lcm_pkg::PROG_W-1:0]   prog_ff, prog_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [ID_W-1:0]              queue_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]              queue_in [QUEUE_DEPTH];
   logic [1:0]                   note_ff, note_in;

   logic                         accept;
   logic [lcm_pkg::Q_W:0]        level_sum;
   logic [lcm_pkg::PROG_W:0]     prog_sum;
   logic [lcm_pkg::PROG_W-1:0]   prog_sat;
   logic [CNT_W-1:0]             count_m1;
   logic [lcm_pkg::Q_W-1:0]      bright_clamp;

   logic                         mul0_start, mul1_start, div_start;
   logic                         mul0_busy, mul1_busy, div_busy;
   logic [lcm_pkg::Q_W-1:0]      mul0_mcand, mul0_mplier, mul1_mcand, mul1_mplier;
   logic [lcm_pkg::Q_W-1:0]      mul0_prod, mul1_prod, div_quot;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= lcm_pkg::Q_ONE;
         dur_ff    <= lcm_pkg::DUR_W'(lcm_pkg::Q_ONE);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == lcm_pkg::CSR_BRIGHTNESS) begin
            bright_ff <= csr_wdata[lcm_pkg::BRIGHT_W-1:0];
         end else if (csr_index == lcm_pkg::CSR_FADE_DURATION) begin
            dur_ff <= csr_wdata[lcm_pkg::DUR_W-1:0];
         end
      end
   end

   // mixer state update on an accepted request beat
   always_comb begin
      enable_in = enable_ff;
      level_in  = level_ff;
      prog_in   = prog_ff;
      count_in  = count_ff;
      queue_in  = queue_ff;
      note_in   = note_ff;
      count_m1  = count_ff - 1'b1;
      level_sum = {1'b0, level_ff} + (lcm_pkg::Q_W + 1)'(req_payload.delta);
      prog_sum  = {1'b0, prog_ff} + (lcm_pkg::PROG_W + 1)'(req_payload.delta);
      prog_sat  = (prog_sum > {1'b0, lcm_pkg::PROG_MAX}) ? lcm_pkg::PROG_MAX
                                                       : prog_sum[lcm_pkg::PROG_W-1:0];
      if (accept) begin
         note_in = lcm_pkg::NOTE_NONE;
         unique case (req_payload.req_type)
            lcm_pkg::REQ_TICK: begin
               // on/off ramp
               if (enable_ff) begin
                  if (level_ff < lcm_pkg::Q_ONE) begin
                     level_in = (level_sum > {1'b0, lcm_pkg::Q_ONE}) ? lcm_pkg::Q_ONE
                                                                   : level_sum[lcm_pkg::Q_W-1:0];
                  end
               end else if (level_ff != '0) begin
                  if (lcm_pkg::Q_W'(req_payload.delta) >= level_ff) begin
                     level_in = '0;
                     note_in  = lcm_pkg::NOTE_OFF;
                  end else begin
                     level_in = level_ff - lcm_pkg::Q_W'(req_payload.delta);
                  end
               end
               // crossfade progress and pop of the faded-out effect
               if (count_ff >= CNT_W'(2)) begin
                  prog_in = prog_sat;
                  if (prog_sat >= lcm_pkg::PROG_W'(dur_ff)) begin
                     for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        queue_in[i] = queue_ff[i+1];
                     end
                     count_in = count_m1;
                     if (count_ff == CNT_W'(2)) begin
                        prog_in = '0;
                     end else begin
                        prog_in = prog_sat - lcm_pkg::PROG_W'(dur_ff);
                     end
                  end
               end
            end
            lcm_pkg::REQ_SWITCH: begin
               if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                  queue_in[QUEUE_DEPTH-1] = req_payload.effect_id;
               end else if ((count_ff == '0) ||
                            (queue_ff[count_m1[IDX_W-1:0]] != req_payload.effect_id)) begin
                  queue_in[count_ff[IDX_W-1:0]] = req_payload.effect_id;
                  count_in = count_ff + 1'b1;
               end
            end
            lcm_pkg::REQ_ENABLE: begin
               if (req_payload.enable_value != enable_ff) begin
                  enable_in = req_payload.enable_value;
                  if (req_payload.enable_value && (level_ff == '0)) begin
                     note_in = lcm_pkg::NOTE_ON;
                  end
               end
            end
            default: begin
               // unknown request: state unchanged
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         level_ff  <= '0;
         prog_ff   <= '0;
         count_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         level_ff  <= level_in;
         prog_ff   <= prog_in;
         count_ff  <= count_in;
      end
      queue_ff <= queue_in;
      note_ff  <= note_in;
   end

   // operand selection for the serial units
   always_comb begin
      bright_clamp = (bright_ff > lcm_pkg::Q_ONE) ? lcm_pkg::Q_ONE : bright_ff;
      mul0_start   = 1'b0;
      mul1_start   = 1'b0;
      div_start    = 1'b0;
      mul0_mcand   = level_ff;
      mul0_mplier  = level_ff;
      mul1_mcand   = mul0_prod;
      mul1_mplier  = div_quot;
      unique case (state_ff)
         S_START: begin
            mul0_start = 1'b1;
            div_start  = 1'b1;
         end
         S_LEV2: begin
            mul0_mcand  = bright_clamp;
            mul0_mplier = mul0_prod;
            mul0_start  = !mul0_busy;
         end
         S_BRIGHT: begin
            mul0_mcand  = mul0_prod;
            mul0_mplier = lcm_pkg::Q_ONE - div_quot;
            mul0_start  = !mul0_busy && !div_busy;
            mul1_start  = !mul0_busy && !div_busy;
         end
         default: begin
         end
      endcase
   end

   lcm_ser_mul u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul0_start),
      .mcand   (mul0_mcand),
      .mplier  (mul0_mplier),
      .busy    (mul0_busy),
      .prod_hi (mul0_prod)
   );

   lcm_ser_mul u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul1_start),
      .mcand   (mul1_mcand),
      .mplier  (mul1_mplier),
      .busy    (mul1_busy),
      .prod_hi (mul1_prod)
   );

   lcm_ser_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prog_ff),
      .den   (dur_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // sequencer and result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_LEV2;
         end
         S_LEV2: begin
            if (!mul0_busy) begin
               state_in = S_BRIGHT;
            end
         end
         S_BRIGHT: begin
            if (!mul0_busy && !div_busy) begin
               state_in = S_WEIGHT;
            end
         end
         S_WEIGHT: begin
            if (!mul0_busy && !mul1_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in               = S_IDLE;
               rsp_valid_in           = 1'b1;
               rsp_in.front_valid     = (count_ff >= CNT_W'(1));
               rsp_in.front_effect    = (count_ff >= CNT_W'(1)) ? queue_ff[0] : '0;
               rsp_in.front_weight    = (count_ff >= CNT_W'(1)) ? mul0_prod : '0;
               rsp_in.next_valid      = (count_ff >= CNT_W'(2));
               rsp_in.next_effect     = (count_ff >= CNT_W'(2)) ? queue_ff[1] : '0;
               rsp_in.next_weight     = (count_ff >= CNT_W'(2)) ? mul1_prod : '0;
               rsp_in.notify          = note_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/lcm_checker.sv @@
// Port-level checks for the LED crossfade mixer, bound to the top level.
module lcm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lcm_pkg::rsp_item_type rsp_payload
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // one request at a time: the input stalls right after a beat is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken before result was formed");

   // empty front slot carries no id, weight or second effect
   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.front_valid |->
         (rsp_payload.front_weight == '0) && (rsp_payload.front_effect == '0) &&
         !rsp_payload.next_valid)
      else $error("front slot empty but fields set");

   // notify only ever carries one of the defined codes
   a_notify_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.notify == lcm_pkg::NOTE_NONE) ||
                    (rsp_payload.notify == lcm_pkg::NOTE_OFF) ||
                    (rsp_payload.notify == lcm_pkg::NOTE_ON))
      else $error("undefined notify code");

endmodule

bind led_effect_crossfade_mixer_core lcm_checker u_checker (.*);
